// File: hdl/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

  localparam int AXIS_W           = 16;
  localparam int SQ_W             = 32;
  localparam int ROOT_W           = 32;
  localparam int REM_W            = 36;
  localparam int NUM_W            = 34;
  localparam int CORD_W           = 36;
  localparam int MAG_W            = 33;
  localparam int ACC_W            = 26;
  localparam int NORM_EXP         = 31;
  localparam int RND_SHIFT        = 10;
  localparam int QUO_W            = ACC_W - RND_SHIFT;
  localparam int RES_W            = QUO_W + 1;
  localparam int TAB_LEN          = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int PITCH_W          = 14;
  localparam int ROLL_W           = 15;
  localparam int PITCH_LIM        = 5760;
  localparam int ROLL_LIM         = 11520;

  localparam logic signed [ACC_W-1:0] DEG180   = ACC_W'(11796480);
  localparam logic        [ACC_W-1:0] RND_HALF = ACC_W'(512);

  typedef struct packed {
    logic signed [CORD_W-1:0] num;
    logic signed [CORD_W-1:0] den;
    logic        [MAG_W-1:0]  mag;
  } vec_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] base;
    logic                    zero;
  } side_t;

  function automatic logic signed [ACC_W-1:0] atan_tab(input int unsigned idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      0:       v = ACC_W'(2949120);
      1:       v = ACC_W'(1740967);
      2:       v = ACC_W'(919879);
      3:       v = ACC_W'(466945);
      4:       v = ACC_W'(234379);
      5:       v = ACC_W'(117304);
      6:       v = ACC_W'(58666);
      7:       v = ACC_W'(29335);
      8:       v = ACC_W'(14668);
      9:       v = ACC_W'(7334);
      10:      v = ACC_W'(3667);
      11:      v = ACC_W'(1833);
      12:      v = ACC_W'(917);
      13:      v = ACC_W'(458);
      14:      v = ACC_W'(229);
      15:      v = ACC_W'(115);
      16:      v = ACC_W'(57);
      17:      v = ACC_W'(29);
      18:      v = ACC_W'(14);
      19:      v = ACC_W'(7);
      20:      v = ACC_W'(4);
      21:      v = ACC_W'(2);
      22:      v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Arithmetic right shift that truncates toward zero.
  function automatic logic signed [CORD_W-1:0] shr_tz(input logic signed [CORD_W-1:0] v,
                                                      input int unsigned k);
    logic signed [CORD_W-1:0] bias;
    bias = v[CORD_W-1] ? CORD_W'((64'd1 << k) - 64'd1) : '0;
    return (v + bias) >>> k;
  endfunction

  // One step of the normalizing shift: shift by k while the larger magnitude stays below 2^31.
  function automatic vec_t norm_step(input vec_t v, input int unsigned k);
    vec_t r;
    r = v;
    if (v.mag < (MAG_W'(1) << (NORM_EXP - k))) begin
      r.num = v.num <<< k;
      r.den = v.den <<< k;
      r.mag = v.mag << k;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/accel_tilt_pitch_roll.sv
// Channel   Ports                                        Direction
// input     in_valid, in_stall, in_accel_x/y/z           sample word in
// output    out_valid, out_stall, out_pitch, out_roll    angle word out
//
// One word is accepted every cycle unless a stalled output word holds the pipeline.
// The pipeline holds the 32-stage square root and one stage per CORDIC micro-rotation.
// Reset is synchronous and clears only the valid bits; in_stall is high while rst_n is low.
// A stalled output word freezes the whole pipeline, and in_stall follows in the same cycle.
`default_nettype none

module accel_tilt_pitch_roll #(
  parameter int CORDIC_STEPS = tpr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_x,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_y,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tpr_pkg::PITCH_W-1:0]  out_pitch,
  output logic signed [tpr_pkg::ROLL_W-1:0]   out_roll
);

  localparam int NUM_W = tpr_pkg::NUM_W;

  logic                                en;
  logic                                mag_vld;
  logic        [tpr_pkg::ROOT_W-1:0]   mag_h;
  logic signed [tpr_pkg::AXIS_W-1:0]   mag_x;
  logic signed [tpr_pkg::AXIS_W-1:0]   mag_y;
  logic signed [tpr_pkg::AXIS_W-1:0]   mag_z;
  logic signed [NUM_W-1:0]             pitch_num;
  logic signed [NUM_W-1:0]             pitch_den;
  logic signed [NUM_W-1:0]             roll_num;
  logic signed [NUM_W-1:0]             roll_den;
  logic                                pitch_vld;
  logic                                roll_vld;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !rst_n || !en;

  tpr_mag u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .x       (in_accel_x),
    .y       (in_accel_y),
    .z       (in_accel_z),
    .out_vld (mag_vld),
    .h       (mag_h),
    .x_o     (mag_x),
    .y_o     (mag_y),
    .z_o     (mag_z)
  );

  assign pitch_num = -(NUM_W'(mag_x) <<< 16);
  assign pitch_den = $signed({{(NUM_W-tpr_pkg::ROOT_W){1'b0}}, mag_h});
  assign roll_num  = NUM_W'(mag_y);
  assign roll_den  = NUM_W'(mag_z);

  tpr_cordic #(
    .STEPS (CORDIC_STEPS),
    .OUT_W (tpr_pkg::PITCH_W),
    .LIM   (tpr_pkg::PITCH_LIM)
  ) u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (mag_vld),
    .num     (pitch_num),
    .den     (pitch_den),
    .out_vld (pitch_vld),
    .angle   (out_pitch)
  );

  tpr_cordic #(
    .STEPS (CORDIC_STEPS),
    .OUT_W (tpr_pkg::ROLL_W),
    .LIM   (tpr_pkg::ROLL_LIM)
  ) u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (mag_vld),
    .num     (roll_num),
    .den     (roll_den),
    .out_vld (roll_vld),
    .angle   (out_roll)
  );

  assign out_valid = pitch_vld && roll_vld;

endmodule

`default_nettype wire

// File: hdl/tpr_mag.sv
`default_nettype none

module tpr_mag (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   x,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   y,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   z,
  output logic                                out_vld,
  output logic        [tpr_pkg::ROOT_W-1:0]   h,
  output logic signed [tpr_pkg::AXIS_W-1:0]   x_o,
  output logic signed [tpr_pkg::AXIS_W-1:0]   y_o,
  output logic signed [tpr_pkg::AXIS_W-1:0]   z_o
);

  localparam int STEPS  = tpr_pkg::ROOT_W;
  localparam int SIDE_W = 3 * tpr_pkg::AXIS_W;
  localparam int SQ_W   = tpr_pkg::SQ_W;
  localparam int ROOT_W = tpr_pkg::ROOT_W;
  localparam int REM_W  = tpr_pkg::REM_W;

  logic signed [SQ_W-1:0] y_ext;
  logic signed [SQ_W-1:0] z_ext;
  logic        [SQ_W-1:0] yy_nxt;
  logic        [SQ_W-1:0] zz_nxt;
  logic                   p_vld_r;
  logic        [SQ_W-1:0] yy_r;
  logic        [SQ_W-1:0] zz_r;
  logic      [SIDE_W-1:0] p_side_r;

  logic                   vld_r  [STEPS+1];
  logic        [SQ_W-1:0] sq_r   [STEPS+1];
  logic      [ROOT_W-1:0] root_r [STEPS+1];
  logic       [REM_W-1:0] rem_r  [STEPS+1];
  logic      [SIDE_W-1:0] side_r [STEPS+1];

  assign y_ext  = SQ_W'(y);
  assign z_ext  = SQ_W'(z);
  assign yy_nxt = y_ext * y_ext;
  assign zz_nxt = z_ext * z_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      p_vld_r  <= in_vld;
      vld_r[0] <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yy_r      <= yy_nxt;
      zz_r      <= zz_nxt;
      p_side_r  <= {x, y, z};
      sq_r[0]   <= yy_r + zz_r;
      root_r[0] <= '0;
      rem_r[0]  <= '0;
      side_r[0] <= p_side_r;
    end
  end

  // Digit-by-digit square root of (y*y + z*z) * 2^32, one result bit per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    logic  [REM_W-1:0] rem_sh;
    logic  [REM_W-1:0] trial;
    logic  [REM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      rem_sh = {rem_r[k][REM_W-3:0], sq_r[k][SQ_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_r[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1]   <= sq_r[k] << 2;
        root_r[k+1] <= root_nxt;
        rem_r[k+1]  <= rem_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld = vld_r[STEPS];
  assign h       = root_r[STEPS];
  assign x_o     = side_r[STEPS][SIDE_W-1 -: tpr_pkg::AXIS_W];
  assign y_o     = side_r[STEPS][2*tpr_pkg::AXIS_W-1 -: tpr_pkg::AXIS_W];
  assign z_o     = side_r[STEPS][tpr_pkg::AXIS_W-1:0];

endmodule

`default_nettype wire

// File: hdl/tpr_cordic.sv
`default_nettype none

module tpr_cordic #(
  parameter int STEPS = tpr_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_W = tpr_pkg::PITCH_W,
  parameter int LIM   = tpr_pkg::PITCH_LIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [tpr_pkg::NUM_W-1:0]  num,
  input  logic signed [tpr_pkg::NUM_W-1:0]  den,
  output logic                              out_vld,
  output logic signed [OUT_W-1:0]           angle
);

  localparam int NUM_W     = tpr_pkg::NUM_W;
  localparam int CORD_W    = tpr_pkg::CORD_W;
  localparam int MAG_W     = tpr_pkg::MAG_W;
  localparam int ACC_W     = tpr_pkg::ACC_W;
  localparam int QUO_W     = tpr_pkg::QUO_W;
  localparam int RES_W     = tpr_pkg::RES_W;
  localparam logic signed [RES_W-1:0] LIM_P = RES_W'(LIM);
  localparam logic signed [RES_W-1:0] LIM_N = -LIM_P;

  logic signed [NUM_W-1:0] q_num_nxt;
  logic signed [NUM_W-1:0] q_den_nxt;
  tpr_pkg::side_t          q_side_nxt;
  logic                    q_vld_r;
  logic signed [NUM_W-1:0] q_num_r;
  logic signed [NUM_W-1:0] q_den_r;
  tpr_pkg::side_t          q_side_r;

  logic signed [NUM_W-1:0] num_abs;
  logic        [MAG_W-1:0] mag_num;
  logic        [MAG_W-1:0] mag_den;
  tpr_pkg::vec_t           v1_nxt;
  tpr_pkg::vec_t           v1_r;
  tpr_pkg::side_t          s1_r;
  logic                    vld1_r;

  tpr_pkg::vec_t           v2_nxt;
  tpr_pkg::vec_t           v2_r;
  tpr_pkg::side_t          s2_r;
  logic                    vld2_r;

  tpr_pkg::vec_t           v3_nxt;

  logic signed [CORD_W-1:0] it_num_r  [STEPS+1];
  logic signed [CORD_W-1:0] it_den_r  [STEPS+1];
  logic signed  [ACC_W-1:0] it_acc_r  [STEPS+1];
  logic                     it_zero_r [STEPS+1];
  logic                     it_vld_r  [STEPS+1];

  logic signed [ACC_W-1:0] fin_acc;
  logic        [ACC_W-1:0] rnd_mag_nxt;
  logic        [ACC_W-1:0] rnd_mag_r;
  logic                    rnd_neg_r;
  logic                    rnd_vld_r;

  logic        [QUO_W-1:0] quo;
  logic signed [RES_W-1:0] res;
  logic signed [RES_W-1:0] res_sat;
  logic signed [OUT_W-1:0] angle_nxt;
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] angle_r;

  // Left half plane: reflect through the origin and start from +-180 degrees.
  always_comb begin
    q_side_nxt.zero = (num == '0) && (den == '0);
    q_side_nxt.base = '0;
    q_num_nxt       = num;
    q_den_nxt       = den;
    if (den < 0) begin
      q_side_nxt.base = (num >= 0) ? tpr_pkg::DEG180 : -tpr_pkg::DEG180;
      q_num_nxt       = -num;
      q_den_nxt       = -den;
    end
  end

  always_comb begin
    num_abs     = (q_num_r < 0) ? -q_num_r : q_num_r;
    mag_num     = MAG_W'(num_abs);
    mag_den     = MAG_W'(q_den_r);
    v1_nxt.num  = CORD_W'(q_num_r);
    v1_nxt.den  = CORD_W'(q_den_r);
    v1_nxt.mag  = (mag_num > mag_den) ? mag_num : mag_den;
  end

  assign v2_nxt = tpr_pkg::norm_step(tpr_pkg::norm_step(v1_r, 16), 8);
  assign v3_nxt = tpr_pkg::norm_step(tpr_pkg::norm_step(tpr_pkg::norm_step(v2_r, 4), 2), 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r     <= 1'b0;
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      it_vld_r[0] <= 1'b0;
    end else if (en) begin
      q_vld_r     <= in_vld;
      vld1_r      <= q_vld_r;
      vld2_r      <= vld1_r;
      it_vld_r[0] <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_num_r      <= q_num_nxt;
      q_den_r      <= q_den_nxt;
      q_side_r     <= q_side_nxt;
      v1_r         <= v1_nxt;
      s1_r         <= q_side_r;
      v2_r         <= v2_nxt;
      s2_r         <= s1_r;
      it_num_r[0]  <= v3_nxt.num;
      it_den_r[0]  <= v3_nxt.den;
      it_acc_r[0]  <= s2_r.base;
      it_zero_r[0] <= s2_r.zero;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [CORD_W-1:0] num_nxt;
    logic signed [CORD_W-1:0] den_nxt;
    logic signed  [ACC_W-1:0] acc_nxt;

    always_comb begin
      dx = tpr_pkg::shr_tz(it_num_r[i], i);
      dy = tpr_pkg::shr_tz(it_den_r[i], i);
      if (it_num_r[i] > 0) begin
        den_nxt = it_den_r[i] + dx;
        num_nxt = it_num_r[i] - dy;
        acc_nxt = it_acc_r[i] + tpr_pkg::atan_tab(i);
      end else begin
        den_nxt = it_den_r[i] - dx;
        num_nxt = it_num_r[i] + dy;
        acc_nxt = it_acc_r[i] - tpr_pkg::atan_tab(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        it_vld_r[i+1] <= it_vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_num_r[i+1]  <= num_nxt;
        it_den_r[i+1]  <= den_nxt;
        it_acc_r[i+1]  <= acc_nxt;
        it_zero_r[i+1] <= it_zero_r[i];
      end
    end
  end

  // Round half away from zero to 1/64 degree, then clamp to the output range.
  always_comb begin
    fin_acc     = it_zero_r[STEPS] ? '0 : it_acc_r[STEPS];
    rnd_mag_nxt = ((fin_acc < 0) ? -fin_acc : fin_acc) + tpr_pkg::RND_HALF;
  end

  always_comb begin
    quo = rnd_mag_r[ACC_W-1:tpr_pkg::RND_SHIFT];
    res = rnd_neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (res > LIM_P) begin
      res_sat = LIM_P;
    end else if (res < LIM_N) begin
      res_sat = LIM_N;
    end else begin
      res_sat = res;
    end
    angle_nxt = OUT_W'(res_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      rnd_vld_r <= it_vld_r[STEPS];
      out_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_mag_r <= rnd_mag_nxt;
      rnd_neg_r <= fin_acc < 0;
      angle_r   <= angle_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign angle   = angle_r;

endmodule

`default_nettype wire

// File: verif/tilt_angle_checker.sv
`timescale 1ns / 1ps

module tilt_angle_checker #(
  parameter int STEPS = tpr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_x,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_y,
  input  logic signed [tpr_pkg::AXIS_W-1:0]   in_accel_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [tpr_pkg::PITCH_W-1:0]  out_pitch,
  input  logic signed [tpr_pkg::ROLL_W-1:0]   out_roll,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);

  localparam longint HALF_TURN  = 64'sd11796480;
  localparam longint NORM_FLOOR = 64'sd1 << 30;

  typedef struct packed {
    logic signed [tpr_pkg::AXIS_W-1:0]  x;
    logic signed [tpr_pkg::AXIS_W-1:0]  y;
    logic signed [tpr_pkg::AXIS_W-1:0]  z;
    logic signed [tpr_pkg::PITCH_W-1:0] pitch;
    logic signed [tpr_pkg::ROLL_W-1:0]  roll;
  } angles_t;

  angles_t angle_queue[$];
  angles_t want;

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic longint micro_angle(input int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned rem, res, bitv;
    rem  = v;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint trunc_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // Vectoring CORDIC; the result is atan2(num, den) in units of 2^-16 degree.
  function automatic longint vector_angle(input longint num_in, input longint den_in);
    longint num, den, base, acc, dx, dy;
    num  = num_in;
    den  = den_in;
    base = 0;
    acc  = 0;
    if (num == 0 && den == 0) return 0;
    if (den < 0) begin
      base = (num >= 0) ? HALF_TURN : -HALF_TURN;
      num  = -num;
      den  = -den;
    end
    while (((num < 0) ? -num : num) < NORM_FLOOR && den < NORM_FLOOR) begin
      num = num * 2;
      den = den * 2;
    end
    for (int i = 0; i < STEPS && i < tpr_pkg::TAB_LEN; i++) begin
      dx = trunc_shift(num, i);
      dy = trunc_shift(den, i);
      if (num > 0) begin
        den = den + dx;
        num = num - dy;
        acc = acc + micro_angle(i);
      end else begin
        den = den - dx;
        num = num + dy;
        acc = acc - micro_angle(i);
      end
    end
    return base + acc;
  endfunction

  function automatic longint to_sixty_fourths(input longint a, input longint lim);
    longint r;
    r = (a >= 0) ? (a + 512) / 1024 : -((-a + 512) / 1024);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t predict_angles(input logic signed [tpr_pkg::AXIS_W-1:0] ax,
                                             input logic signed [tpr_pkg::AXIS_W-1:0] ay,
                                             input logic signed [tpr_pkg::AXIS_W-1:0] az);
    angles_t a;
    longint x, y, z, h, p, r;
    longint unsigned sq;
    x  = longint'(ax);
    y  = longint'(ay);
    z  = longint'(az);
    sq = y * y + z * z;
    h  = root_floor(sq << 32);
    p  = to_sixty_fourths(vector_angle(-x * 65536, h), tpr_pkg::PITCH_LIM);
    r  = to_sixty_fourths(vector_angle(y, z), tpr_pkg::ROLL_LIM);
    a.x     = ax;
    a.y     = ay;
    a.z     = az;
    a.pitch = p[tpr_pkg::PITCH_W-1:0];
    a.roll  = r[tpr_pkg::ROLL_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      angle_queue.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (in_valid && !in_stall) begin
        angle_queue.push_back(predict_angles(in_accel_x, in_accel_y, in_accel_z));
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (angle_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected angle word: pitch %0d, roll %0d", $time, out_pitch,
                   out_roll);
        end else begin
          want = angle_queue.pop_front();
          if (out_pitch !== want.pitch) begin
            errors++;
            $display("%0t: pitch for (%0d, %0d, %0d): expected %0d, actual %0d", $time,
                     want.x, want.y, want.z, want.pitch, out_pitch);
          end
          if (out_roll !== want.roll) begin
            errors++;
            $display("%0t: roll for (%0d, %0d, %0d): expected %0d, actual %0d", $time,
                     want.x, want.y, want.z, want.roll, out_roll);
          end
        end
      end
    end
    pending = angle_queue.size();
  end

endmodule

// File: verif/accel_tilt_pitch_roll_test.sv
`timescale 1ns / 1ps

module accel_tilt_pitch_roll_test;

  localparam int LATENCY  = tpr_pkg::CORDIC_STEPS_DEF + 40;
  localparam int HOLD_LEN = 300;
  localparam logic [4:0][tpr_pkg::AXIS_W-1:0] CORNERS =
      {16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001};

  typedef struct packed {
    logic signed [tpr_pkg::AXIS_W-1:0] x;
    logic signed [tpr_pkg::AXIS_W-1:0] y;
    logic signed [tpr_pkg::AXIS_W-1:0] z;
  } sample_t;

  typedef enum int {SHAPE_ANY, SHAPE_TILT, SHAPE_TINY, SHAPE_AXIS, SHAPE_CORNER, SHAPE_FLIP}
      shape_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               out_stall = 1'b0;
  logic signed [tpr_pkg::AXIS_W-1:0]  in_accel_x = '0;
  logic signed [tpr_pkg::AXIS_W-1:0]  in_accel_y = '0;
  logic signed [tpr_pkg::AXIS_W-1:0]  in_accel_z = '0;
  wire                                in_stall;
  wire                                out_valid;
  wire signed [tpr_pkg::PITCH_W-1:0]  out_pitch;
  wire signed [tpr_pkg::ROLL_W-1:0]   out_roll;

  int errors;
  int pending;
  int checked;
  int sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #1 clk = ~clk;

  accel_tilt_pitch_roll u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pitch  (out_pitch),
    .out_roll   (out_roll)
  );

  tilt_angle_checker u_angle_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pitch  (out_pitch),
    .out_roll   (out_roll),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= s.x;
    in_accel_y <= s.y;
    in_accel_z <= s.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    shape_t shape;
    pick  = $urandom_range(8);
    shape = (pick < 4) ? SHAPE_ANY : shape_t'(pick - 3);
    s.x   = 16'($urandom);
    s.y   = 16'($urandom);
    s.z   = 16'($urandom);
    case (shape)
      SHAPE_TILT: begin
        s.x = 16'(int'($urandom_range(40000)) - 20000);
        s.y = 16'(int'($urandom_range(40000)) - 20000);
        s.z = 16'(int'($urandom_range(40000)) - 20000);
      end
      SHAPE_TINY: begin
        s.x = 16'(int'($urandom_range(8)) - 4);
        s.y = 16'(int'($urandom_range(8)) - 4);
        s.z = 16'(int'($urandom_range(8)) - 4);
      end
      SHAPE_AXIS: begin
        if ($urandom_range(1) == 0) s.y = '0;
        else s.z = '0;
        if ($urandom_range(2) == 0) s.x = '0;
      end
      SHAPE_CORNER: begin
        s.x = CORNERS[$urandom_range(4)];
        s.y = CORNERS[$urandom_range(4)];
        s.z = CORNERS[$urandom_range(4)];
      end
      SHAPE_FLIP: begin
        s.y = 16'(int'($urandom_range(4)) - 2);
        s.z = 16'(-int'($urandom_range(32768, 1)));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_word(random_sample());
  endtask

  initial begin
    sample_t directed[$];
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768},
      '{-16'sd32768, 16'sd0, 16'sd0},
      '{16'sd32767, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, -16'sd32768},
      '{16'sd0, 16'sd0, 16'sd32767},
      '{16'sd0, 16'sd32767, 16'sd0},
      '{16'sd0, -16'sd32768, 16'sd0},
      '{16'sd0, -16'sd1, -16'sd32768},
      '{16'sd0, 16'sd1, -16'sd32768},
      '{16'sd0, 16'sd0, -16'sd1},
      '{16'sd1, 16'sd0, 16'sd0},
      '{-16'sd1, 16'sd0, 16'sd0},
      '{16'sd0, -16'sd32768, -16'sd32768},
      '{16'sd0, 16'sd32767, -16'sd32768},
      '{16'sd16384, 16'sd0, 16'sd16384},
      '{-16'sd32768, -16'sd32768, 16'sd32767},
      '{16'sd0, 16'sd1, 16'sd1},
      '{16'sd5, -16'sd3, -16'sd7},
      '{16'sd0, 16'sd0, 16'sd1}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i]);
    send_random(90);

    send_idle_pct = 78;
    send_random(80);
    go_quiet();
    wait (pending == 0);

    send_idle_pct = 0;
    stall_pct     = 78;
    send_random(80);

    send_idle_pct = 34;
    stall_pct     = 34;
    send_random(80);

    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    send_random(90);

    go_quiet();
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d samples and checked %0d angle words: extremes, zero vectors, axis cases,",
             sent, checked);
    $display("and random vectors under four idle/stall mixes plus a %0d-cycle output hold.",
             HOLD_LEN);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: accel_tilt_pitch_roll.f
hdl/tpr_pkg.sv
hdl/tpr_mag.sv
hdl/tpr_cordic.sv
hdl/accel_tilt_pitch_roll.sv
verif/tilt_angle_checker.sv
verif/accel_tilt_pitch_roll_test.sv
